>>> rtl/svmks_pkg.sv
// Shared types, constants and the exp table builder for the SVM kernel similarity block.
package svmks_pkg;

  localparam int ELEM_W     = 16;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int MAG_W      = ELEM_W;
  localparam int ACC_W      = 48;
  localparam int OUT_W      = 48;
  localparam int PF         = 2 * (ELEM_W - 4);
  localparam int ISIG_W     = 24;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int EXP_DEPTH  = 256;
  localparam int EXP_IDX_W  = 8;
  localparam int EXP_W      = 33;
  localparam int MUL_W      = 33;
  localparam int TM_W       = 25;

  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TANH   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_GAUSS  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_SIGMA   = 2'd1;

  localparam logic [MODE_W-1:0] KERNEL_MODE_RST = MODE_GAUSS;
  localparam logic [ISIG_W-1:0] INV_SIGMA_RST   = 24'd65536;

  localparam logic signed [ACC_W-1:0] TANH_KNEE = 48'sd32217623;
  localparam logic [OUT_W-1:0]        TANH_SAT  = 48'd16108812;
  localparam logic [MUL_W-1:0]        C_TANH    = 33'd1118294684;
  localparam logic [MUL_W-1:0]        C_LOG2E   = 33'd6196328019;
  localparam logic [63:0]             C_LN2     = 64'd2977044472;

  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic [ACC_W-1:0]        dist_sq;
    logic [MODE_W-1:0]       mode;
    logic [ISIG_W-1:0]       isig;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef logic [EXP_W-1:0] exp_rom_t [EXP_DEPTH];

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t    rom;
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    for (int i = 0; i < EXP_DEPTH; i++) begin
      x    = (64'(i) * C_LN2) / EXP_DEPTH;
      term = 64'd1 << 32;
      pos  = term;
      neg  = 64'd0;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * x) >> 32) / 64'(n);
        if (n[0]) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      rom[i] = EXP_W'(pos - neg);
    end
    return rom;
  endfunction

endpackage

>>> rtl/svm_kernel_similarity_top.sv
// Top level of the streaming SVM kernel similarity evaluator.
// Input channel: one (x, y) element pair per request, Q3.12 each, in_last closes
// the vector pair. A request is taken when in_valid is high and in_stall is low;
// pairs are accepted back to back, one per cycle, while in_stall stays low.
// Output channel: one Q23.24 kernel value per vector pair, held in an output
// register until taken (out_valid high, out_stall low).
// Config channel: cfg_index 0 selects kernel_mode (0 linear, 1 tanh, 2 Gaussian,
// 3 gives zero), cfg_index 1 selects inv_sigma (Q8.16); cfg_ready is always high.
// Linear, unused mode and saturated tanh go from idle straight to the done state;
// tanh passes the square, coefficient and finish states, Gaussian the multiply,
// add, log2e and exp table states. The evaluator works on one result at a time
// through the shared 33x33 multiplier; finished accumulations wait in a QUEUE_DEPTH
// request queue, and in_stall rises only when a last pair finds that queue full.
// Reset clears both accumulators, the queue and the output valid flag, and sets
// kernel_mode to Gaussian and inv_sigma to 1.0.
// A stalled receiver holds the output register; the evaluator then waits with
// its next result and the queue fills before the input side stalls.
module svm_kernel_similarity_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [svmks_pkg::ELEM_W-1:0]   in_x_elem,
  input  logic signed [svmks_pkg::ELEM_W-1:0]   in_y_elem,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [svmks_pkg::OUT_W-1:0]    out_similarity,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [svmks_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [svmks_pkg::ISIG_W-1:0]          cfg_wdata
);

  logic [svmks_pkg::MODE_W-1:0] kernel_mode_r;
  logic [svmks_pkg::ISIG_W-1:0] inv_sigma_r;
  svmks_pkg::q_stat_t           q_stat;
  svmks_pkg::q_entry_t          q_wdata;
  svmks_pkg::q_entry_t          q_rdata;
  logic                         q_push;
  logic                         q_pop;
  logic [svmks_pkg::OUT_W-1:0]  sim;

  assign cfg_ready      = 1'b1;
  assign out_similarity = sim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_mode_r <= svmks_pkg::KERNEL_MODE_RST;
      inv_sigma_r   <= svmks_pkg::INV_SIGMA_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        svmks_pkg::REG_KERNEL_MODE: kernel_mode_r <= cfg_wdata[svmks_pkg::MODE_W-1:0];
        svmks_pkg::REG_INV_SIGMA:   inv_sigma_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  svmks_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_x_elem   (in_x_elem),
    .in_y_elem   (in_y_elem),
    .in_last     (in_last),
    .kernel_mode (kernel_mode_r),
    .inv_sigma   (inv_sigma_r),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_wdata     (q_wdata)
  );

  svmks_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  svmks_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_data         (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_similarity (sim)
  );

endmodule

>>> rtl/svmks_queue.sv
// Request queue between the accumulating front and the kernel evaluation back end.
module svmks_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  svmks_pkg::q_entry_t  wdata,
  input  logic                 pop,
  output svmks_pkg::q_entry_t  rdata,
  output svmks_pkg::q_stat_t   stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  svmks_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  assign rdata      = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> rtl/svmks_front.sv
// Front end: element pair products and saturating dot and distance accumulation.
module svmks_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [svmks_pkg::ELEM_W-1:0]   in_x_elem,
  input  logic signed [svmks_pkg::ELEM_W-1:0]   in_y_elem,
  input  logic                                  in_last,
  input  logic [svmks_pkg::MODE_W-1:0]          kernel_mode,
  input  logic [svmks_pkg::ISIG_W-1:0]          inv_sigma,
  input  svmks_pkg::q_stat_t                    q_stat,
  output logic                                  q_push,
  output svmks_pkg::q_entry_t                   q_wdata
);

  localparam int ACC_W  = svmks_pkg::ACC_W;
  localparam int PROD_W = svmks_pkg::PROD_W;
  localparam int ELEM_W = svmks_pkg::ELEM_W;
  localparam int MAG_W  = svmks_pkg::MAG_W;

  logic                     s1_valid_r;
  logic                     s1_last_r;
  logic signed [PROD_W-1:0] p_r, p_nxt;
  logic [PROD_W-1:0]        sq_r, sq_nxt;
  logic signed [ACC_W-1:0]  dot_r, dot_nxt;
  logic [ACC_W-1:0]         dist_r, dist_nxt;

  logic signed [ELEM_W:0]   diff;
  logic [MAG_W-1:0]         mag;
  logic                     hold;
  logic                     advance;
  logic [ACC_W:0]           dsum;
  logic [ACC_W:0]           usum;

  assign hold     = s1_valid_r & s1_last_r & q_stat.full;
  assign in_stall = hold;
  assign advance  = s1_valid_r & ~hold;

  assign diff  = $signed({in_x_elem[ELEM_W-1], in_x_elem}) -
                 $signed({in_y_elem[ELEM_W-1], in_y_elem});
  assign mag   = diff[ELEM_W] ? MAG_W'(-diff) : MAG_W'(diff);
  assign p_nxt = in_x_elem * in_y_elem;
  assign sq_nxt = mag * mag;

  assign dsum = {dot_r[ACC_W-1], dot_r} + {{(ACC_W + 1 - PROD_W){p_r[PROD_W-1]}}, p_r};
  assign usum = {1'b0, dist_r} + (ACC_W + 1)'(sq_r);

  always_comb begin
    if (dsum[ACC_W] != dsum[ACC_W-1]) begin
      dot_nxt = dsum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}} : {1'b0, {(ACC_W - 1){1'b1}}};
    end else begin
      dot_nxt = dsum[ACC_W-1:0];
    end
    dist_nxt = usum[ACC_W] ? {ACC_W{1'b1}} : usum[ACC_W-1:0];
  end

  assign q_push          = advance & s1_last_r;
  assign q_wdata.dot     = dot_nxt;
  assign q_wdata.dist_sq = dist_nxt;
  assign q_wdata.mode    = kernel_mode;
  assign q_wdata.isig    = inv_sigma;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      dot_r      <= '0;
      dist_r     <= '0;
    end else begin
      if (!hold) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        dot_r  <= s1_last_r ? '0 : dot_nxt;
        dist_r <= s1_last_r ? '0 : dist_nxt;
      end
    end
    if (!hold) begin
      s1_last_r <= in_last;
      p_r       <= p_nxt;
      sq_r      <= sq_nxt;
    end
  end

endmodule

>>> rtl/svmks_back.sv
// Back end: sequenced linear, tanh and Gaussian kernel evaluation with output register.
module svmks_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  svmks_pkg::q_stat_t              q_stat,
  input  svmks_pkg::q_entry_t             q_data,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [svmks_pkg::OUT_W-1:0]     out_similarity
);

  localparam int ACC_W     = svmks_pkg::ACC_W;
  localparam int OUT_W     = svmks_pkg::OUT_W;
  localparam int MUL_W     = svmks_pkg::MUL_W;
  localparam int TM_W      = svmks_pkg::TM_W;
  localparam int ISIG_W    = svmks_pkg::ISIG_W;
  localparam int PF        = svmks_pkg::PF;
  localparam int EXP_IDX_W = svmks_pkg::EXP_IDX_W;
  localparam int EXP_W     = svmks_pkg::EXP_W;
  localparam int HALF_D    = ACC_W / 2;
  localparam int A_W       = ACC_W + ISIG_W - 16;
  localparam int HALF_A    = A_W / 2;
  localparam int PACC_W    = HALF_A + MUL_W;
  localparam int B_W       = A_W + 1;
  localparam int K_W       = B_W - PF;

  localparam svmks_pkg::exp_rom_t EXP_ROM = svmks_pkg::build_exp_rom();

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_SQ,
    ST_T_CO,
    ST_T_FIN,
    ST_G_M0,
    ST_G_M1,
    ST_G_A,
    ST_G_B0,
    ST_G_B1,
    ST_G_BA,
    ST_G_EXP,
    ST_DONE
  } state_t;

  state_t                 state_r, state_nxt;
  logic [TM_W-1:0]        m_r, m_nxt;
  logic                   neg_r, neg_nxt;
  logic [ACC_W-1:0]       dist_r, dist_nxt;
  logic [ISIG_W-1:0]      isig_r, isig_nxt;
  logic [2*MUL_W-1:0]     prod_r, prod_nxt;
  logic [PACC_W-1:0]      acc_r, acc_nxt;
  logic [A_W-1:0]         a_r, a_nxt;
  logic [B_W-1:0]         b_r, b_nxt;
  logic [OUT_W-1:0]       res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_sim_r, out_sim_nxt;

  logic [MUL_W-1:0]       mul_a;
  logic [MUL_W-1:0]       mul_b;
  logic [2*MUL_W-1:0]     product;
  logic [ACC_W-1:0]       dot_abs;
  logic [A_W+16:0]        sum_a;
  logic [PACC_W+HALF_A:0] sum_b;
  logic [TM_W-1:0]        tanh_r;
  logic [K_W-1:0]         k_val;
  logic [EXP_IDX_W-1:0]   idx;
  logic [5:0]             sh;

  assign product = mul_a * mul_b;
  assign dot_abs = q_data.dot[ACC_W-1] ? (ACC_W'(0) - q_data.dot) : q_data.dot;
  assign sum_a   = (A_W + 17)'(acc_r) + ((A_W + 17)'(prod_r[2*HALF_D-1:0]) << HALF_D);
  assign sum_b   = (PACC_W + HALF_A + 1)'(acc_r) +
                   ((PACC_W + HALF_A + 1)'(prod_r[PACC_W-1:0]) << HALF_A);
  assign tanh_r  = m_r - prod_r[32+TM_W-1:32];
  assign k_val   = b_r[B_W-1:PF];
  assign idx     = b_r[PF-1 -: EXP_IDX_W];
  assign sh      = 6'(k_val[4:0]) + 6'(32 - PF);

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    neg_nxt       = neg_r;
    dist_nxt      = dist_r;
    isig_nxt      = isig_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_sim_nxt   = out_sim_r;
    q_pop         = 1'b0;
    mul_a         = '0;
    mul_b         = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          unique case (q_data.mode)
            svmks_pkg::MODE_LINEAR: begin
              res_nxt   = OUT_W'(q_data.dot);
              state_nxt = ST_DONE;
            end
            svmks_pkg::MODE_TANH: begin
              if ($signed(q_data.dot) > svmks_pkg::TANH_KNEE) begin
                res_nxt   = svmks_pkg::TANH_SAT;
                state_nxt = ST_DONE;
              end else if ($signed(q_data.dot) <= -svmks_pkg::TANH_KNEE) begin
                res_nxt   = OUT_W'(0) - svmks_pkg::TANH_SAT;
                state_nxt = ST_DONE;
              end else begin
                m_nxt     = dot_abs[TM_W-1:0];
                neg_nxt   = q_data.dot[ACC_W-1];
                state_nxt = ST_T_SQ;
              end
            end
            svmks_pkg::MODE_GAUSS: begin
              dist_nxt  = q_data.dist_sq;
              isig_nxt  = q_data.isig;
              state_nxt = ST_G_M0;
            end
            default: begin
              res_nxt   = '0;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_T_SQ: begin
        mul_a     = MUL_W'(m_r);
        mul_b     = MUL_W'(m_r);
        prod_nxt  = product;
        state_nxt = ST_T_CO;
      end
      ST_T_CO: begin
        mul_a     = MUL_W'(prod_r[PF+TM_W:PF]);
        mul_b     = svmks_pkg::C_TANH;
        prod_nxt  = product;
        state_nxt = ST_T_FIN;
      end
      ST_T_FIN: begin
        res_nxt   = neg_r ? (OUT_W'(0) - OUT_W'(tanh_r)) : OUT_W'(tanh_r);
        state_nxt = ST_DONE;
      end
      ST_G_M0: begin
        mul_a     = MUL_W'(dist_r[HALF_D-1:0]);
        mul_b     = MUL_W'(isig_r);
        prod_nxt  = product;
        state_nxt = ST_G_M1;
      end
      ST_G_M1: begin
        acc_nxt   = prod_r[PACC_W-1:0];
        mul_a     = MUL_W'(dist_r[ACC_W-1:HALF_D]);
        mul_b     = MUL_W'(isig_r);
        prod_nxt  = product;
        state_nxt = ST_G_A;
      end
      ST_G_A: begin
        a_nxt     = sum_a[A_W+15:16];
        state_nxt = ST_G_B0;
      end
      ST_G_B0: begin
        mul_a     = MUL_W'(a_r[HALF_A-1:0]);
        mul_b     = svmks_pkg::C_LOG2E;
        prod_nxt  = product;
        state_nxt = ST_G_B1;
      end
      ST_G_B1: begin
        acc_nxt   = prod_r[PACC_W-1:0];
        mul_a     = MUL_W'(a_r[A_W-1:HALF_A]);
        mul_b     = svmks_pkg::C_LOG2E;
        prod_nxt  = product;
        state_nxt = ST_G_BA;
      end
      ST_G_BA: begin
        b_nxt     = sum_b[B_W+31:32];
        state_nxt = ST_G_EXP;
      end
      ST_G_EXP: begin
        if (k_val >= K_W'(25)) begin
          res_nxt = '0;
        end else begin
          res_nxt = OUT_W'(EXP_ROM[idx] >> sh);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sim_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_similarity = out_sim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    m_r       <= m_nxt;
    neg_r     <= neg_nxt;
    dist_r    <= dist_nxt;
    isig_r    <= isig_nxt;
    prod_r    <= prod_nxt;
    acc_r     <= acc_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    res_r     <= res_nxt;
    out_sim_r <= out_sim_nxt;
  end

endmodule

>>> rtl/svmks_checker.sv
// Port-level checker for the SVM kernel similarity block and its bind.
module svmks_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [svmks_pkg::OUT_W-1:0]    out_similarity
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_similarity))
    else $error("result changed while stalled");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_rst_stall: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind svm_kernel_similarity_top svmks_checker u_svmks_checker (.*);

>>> test/tb_svm_kernel_similarity_top.sv
// Self-checking testbench for svm_kernel_similarity_top: streams element pairs and checks every kernel value.
`timescale 1ns / 1ps

module tb_svm_kernel_similarity_top;
  import svmks_pkg::*;

  localparam int          HALF_PERIOD   = 6;
  localparam int          RESET_CYCLES  = 11;
  localparam int          QUIET_LIMIT   = 4000;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          TAIL_CYCLES   = 20;
  localparam int          SAT_PAIRS     = 40;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam longint      DOT_MAX       = 64'sd140737488355327;
  localparam longint      DOT_MIN       = -64'sd140737488355328;
  localparam longint unsigned DIST_MAX  = 64'd281474976710655;
  localparam longint      KNEE_Q24      = 64'sd32217623;
  localparam longint      TANH_SAT_Q24  = 64'sd16108812;
  localparam longint unsigned TANH_COEF_Q32 = 64'd1118294684;
  localparam longint unsigned LOG2E_Q32     = 64'd6196328019;
  localparam longint unsigned LN2_Q32       = 64'd2977044472;

  typedef struct {
    logic signed [ELEM_W-1:0] x;
    logic signed [ELEM_W-1:0] y;
    logic                     last;
  } pair_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic signed [ELEM_W-1:0]    in_x_elem = '0;
  logic signed [ELEM_W-1:0]    in_y_elem = '0;
  logic                        in_last = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [OUT_W-1:0]     out_similarity;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [ISIG_W-1:0]           cfg_wdata = '0;

  pair_t                       pair_q[$];
  pair_t                       next_pair;
  logic signed [OUT_W-1:0]     kernel_due[$];
  logic [63:0]                 pow2_frac[EXP_DEPTH];
  logic [MODE_W-1:0]           mode_now;
  logic [ISIG_W-1:0]           isig_now;
  longint                      dot_sum;
  longint unsigned             dist_sum;
  logic                        in_took = 1'b0;
  int                          quiet_cycles = 0;
  int                          mismatches = 0;
  int unsigned                 send_gap_pct = 0;
  int unsigned                 stall_pct = 0;
  logic                        hold_arm = 1'b0;
  logic                        hold_done = 1'b0;
  int                          hold_left = 0;

  svm_kernel_similarity_top uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_x_elem      (in_x_elem),
    .in_y_elem      (in_y_elem),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_similarity (out_similarity),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic longint tanh_kernel(longint d);
    longint unsigned mag;
    longint unsigned sq;
    longint unsigned corr;
    longint          r;
    if (d > KNEE_Q24) return TANH_SAT_Q24;
    if (d <= -KNEE_Q24) return -TANH_SAT_Q24;
    mag  = (d < 0) ? longint'(-d) : longint'(d);
    sq   = (mag * mag) >> PF;
    corr = (sq * TANH_COEF_Q32) >> 32;
    r    = longint'(mag - corr);
    return (d < 0) ? -r : r;
  endfunction

  function automatic longint gauss_kernel(longint unsigned dsq_in, logic [ISIG_W-1:0] isig);
    logic [127:0] wide;
    logic [63:0]  scaled;
    logic [63:0]  expo;
    logic [63:0]  k;
    logic [7:0]   idx;
    wide   = 128'(dsq_in) * 128'(isig);
    scaled = (wide[127:80] != 0) ? '1 : wide[79:16];
    wide   = 128'(scaled) * 128'(LOG2E_Q32);
    expo   = (wide[127:96] != 0) ? '1 : wide[95:32];
    k      = expo >> PF;
    idx    = expo[23:16];
    if (k >= 56) return 0;
    return longint'(pow2_frac[idx] >> (8 + k));
  endfunction

  function automatic void fold_pair(logic signed [ELEM_W-1:0] x, logic signed [ELEM_W-1:0] y,
                                    logic last);
    longint          prod;
    longint          diff;
    longint unsigned sq;
    longint          kv;
    prod = longint'(x) * longint'(y);
    diff = longint'(x) - longint'(y);
    sq   = longint'(diff * diff);
    dot_sum = dot_sum + prod;
    if (dot_sum > DOT_MAX) begin
      dot_sum = DOT_MAX;
    end else if (dot_sum < DOT_MIN) begin
      dot_sum = DOT_MIN;
    end
    dist_sum = dist_sum + sq;
    if (dist_sum > DIST_MAX) begin
      dist_sum = DIST_MAX;
    end
    if (last) begin
      case (mode_now)
        MODE_LINEAR: kv = dot_sum;
        MODE_TANH:   kv = tanh_kernel(dot_sum);
        MODE_GAUSS:  kv = gauss_kernel(dist_sum, isig_now);
        default:     kv = 0;
      endcase
      kernel_due.push_back(OUT_W'(kv));
      dot_sum  = 0;
      dist_sum = 0;
    end
  endfunction

  function automatic void queue_pair(int x, int y, logic last);
    pair_t p;
    p.x    = ELEM_W'(x);
    p.y    = ELEM_W'(y);
    p.last = last;
    pair_q.push_back(p);
  endfunction

  function automatic int extreme_elem();
    case ($urandom_range(4))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic void queue_vector(int unsigned len);
    int unsigned pick;
    int unsigned span;
    int          x;
    int          y;
    for (int unsigned i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        span = $urandom_range(1) ? 3000 : 12000;
        x = int'($urandom_range(span)) - int'(span / 2);
        y = int'($urandom_range(span)) - int'(span / 2);
      end else if (pick < 60) begin
        span = $urandom_range(1) ? 80 : 8000;
        x = int'($urandom_range(65535)) - 32768;
        y = x + int'($urandom_range(span)) - int'(span / 2);
      end else if (pick < 80) begin
        x = int'($urandom_range(65535)) - 32768;
        y = int'($urandom_range(65535)) - 32768;
      end else begin
        x = extreme_elem();
        y = extreme_elem();
      end
      queue_pair(x, y, i == len - 1);
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ISIG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input logic [MODE_W-1:0] mode, input logic [ISIG_W-1:0] isig);
    write_reg(REG_KERNEL_MODE, ISIG_W'(mode));
    write_reg(REG_INV_SIGMA, isig);
  endtask

  task automatic settle();
    while (pair_q.size() != 0 || in_valid || kernel_due.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pair_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_pair = pair_q.pop_front();
        in_valid  <= 1'b1;
        in_x_elem <= next_pair.x;
        in_y_elem <= next_pair.y;
        in_last   <= next_pair.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_arm && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left != 0) begin
      hold_left--;
    end
    out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_now     = MODE_GAUSS;
      isig_now     = 24'd65536;
      dot_sum      = 0;
      dist_sum     = 0;
      in_took      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KERNEL_MODE: mode_now = cfg_wdata[MODE_W-1:0];
          REG_INV_SIGMA:   isig_now = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        fold_pair(in_x_elem, in_y_elem, in_last);
      end
      if (out_valid && !out_stall) begin
        if (kernel_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("similarity %0d arrived with nothing pending", out_similarity);
          end
          mismatches++;
        end else if (out_similarity !== kernel_due[0]) begin
          if (mismatches < 10) begin
            $display("similarity mismatch: expected %0d got %0d", kernel_due[0],
                     out_similarity);
          end
          mismatches++;
          void'(kernel_due.pop_front());
        end else begin
          void'(kernel_due.pop_front());
        end
      end
      in_took      <= in_valid && !in_stall;
      quiet_cycles <= ((cfg_valid && cfg_ready) || (in_valid && !in_stall) ||
                       (out_valid && !out_stall)) ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [63:0]       xarg;
    logic [63:0]       term;
    logic [63:0]       plus;
    logic [63:0]       minus;
    logic [MODE_W-1:0] mode_plan[12];
    int unsigned       isig_plan[12];
    int unsigned       send_plan[4];
    int unsigned       stall_plan[4];
    int unsigned       queued;
    int unsigned       len;
    logic [ISIG_W-1:0] isig;

    mode_plan  = '{MODE_GAUSS, MODE_LINEAR, MODE_TANH, MODE_GAUSS, MODE_UNUSED, MODE_GAUSS,
                   MODE_TANH, MODE_LINEAR, MODE_GAUSS, MODE_TANH, MODE_GAUSS, MODE_GAUSS};
    isig_plan  = '{65536, 0, 0, 1, 16777215, 16777215, 65536, 0, 0, 0, 4096, 0};
    send_plan  = '{0, 55, 0, 16};
    stall_plan = '{0, 0, 55, 16};

    for (int i = 0; i < EXP_DEPTH; i++) begin
      xarg  = (64'(i) * LN2_Q32) / EXP_DEPTH;
      term  = 64'd1 << 32;
      plus  = term;
      minus = 64'd0;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * xarg) >> 32) / 64'(n);
        if (n % 2 == 1) begin
          minus = minus + term;
        end else begin
          plus = plus + term;
        end
      end
      pow2_frac[i] = plus - minus;
    end

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Gaussian at reset setting: zero distance, huge distance, two-pair vector
    queue_pair(0, 0, 1'b1);
    queue_pair(32767, -32768, 1'b1);
    queue_pair(4096, 2048, 1'b0);
    queue_pair(-1, 1, 1'b1);
    settle();

    apply_setting(MODE_LINEAR, 24'd65536);
    queue_pair(-32768, -32768, 1'b1);
    queue_pair(32767, -32768, 1'b1);
    queue_pair(1, -1, 1'b1);
    settle();

    // tanh: mid range, both knees exactly, zero
    apply_setting(MODE_TANH, 24'd65536);
    queue_pair(4096, 4096, 1'b1);
    queue_pair(-4096, 4096, 1'b1);
    queue_pair(5676, 5676, 1'b0);
    queue_pair(647, 1, 1'b1);
    queue_pair(5676, -5676, 1'b0);
    queue_pair(647, -1, 1'b1);
    queue_pair(0, 0, 1'b1);
    queue_pair(100, 200, 1'b0);
    settle();

    // mode changes between the pairs of one vector
    write_reg(REG_KERNEL_MODE, ISIG_W'(MODE_LINEAR));
    queue_pair(3, 5, 1'b1);
    settle();

    write_reg(REG_KERNEL_MODE, ISIG_W'(MODE_UNUSED));
    queue_pair(1000, 2000, 1'b1);
    settle();

    apply_setting(MODE_GAUSS, 24'd0);
    queue_pair(4096, 0, 1'b1);
    settle();

    // long vectors of extreme pairs for large accumulations
    apply_setting(MODE_LINEAR, 24'd1);
    for (int i = 0; i < SAT_PAIRS; i++) begin
      queue_pair(-32768, 32767, 1'b0);
    end
    queue_pair(-32768, 32767, 1'b1);
    for (int i = 0; i < SAT_PAIRS; i++) begin
      queue_pair(-32768, -32768, 1'b0);
    end
    queue_pair(5, 5, 1'b0);
    queue_pair(-32768, -32768, 1'b1);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      send_gap_pct = send_plan[ph % 4];
      stall_pct    = stall_plan[ph % 4];
      if (isig_plan[ph] != 0) begin
        isig = ISIG_W'(isig_plan[ph]);
      end else begin
        isig = $urandom_range(1) ? ISIG_W'($urandom_range(262144, 1))
                                 : ISIG_W'($urandom_range(16777215, 1));
      end
      apply_setting(mode_plan[ph], isig);
      queued = 0;
      while (queued < 135) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        queue_vector(len);
        queued += len;
      end
      settle();
    end

    // hold the receiver off while short vectors keep coming
    send_gap_pct = 0;
    stall_pct    = 0;
    apply_setting(MODE_TANH, 24'd65536);
    hold_arm = 1'b1;
    for (int i = 0; i < 60; i++) begin
      queue_vector(1);
    end
    settle();

    if (mismatches == 0 && kernel_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/svmks_pkg.sv
rtl/svmks_queue.sv
rtl/svmks_front.sv
rtl/svmks_back.sv
rtl/svm_kernel_similarity_top.sv
rtl/svmks_checker.sv
test/tb_svm_kernel_similarity_top.sv
